// ===== rtl/core/pwcd_pkg.sv =====
// Shared types and constants for the pulse-width remote code decoder.
// No dependencies; used by pwcd_check and rf_pulse_width_code_decoder.
package pwcd_pkg;

  localparam int TIME_W     = 32;
  localparam int WIDTH_W    = 16;
  localparam int FRAME_W    = 12;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CODE_BITS_DEF = 12;

  localparam logic [WIDTH_W-1:0] SHORT_MIN_RST = 16'd200;
  localparam logic [WIDTH_W-1:0] SHORT_MAX_RST = 16'd600;
  localparam logic [WIDTH_W-1:0] STOP_MIN_RST  = 16'd4000;
  localparam logic               MSB_FIRST_RST = 1'b0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SHORT_MIN = 2'd0,
    CFG_SHORT_MAX = 2'd1,
    CFG_STOP_MIN  = 2'd2,
    CFG_MSB_FIRST = 2'd3
  } cfg_idx_t;

  // Outcome of the timing checks for one edge
  typedef struct packed {
    logic sync_start;
    logic half_ok;
    logic cycle_ok;
    logic bit_val;
  } check_t;

endpackage

// ===== rtl/core/pwcd_check.sv =====
// Timing checks for one edge: sync detection, half-period and cycle windows, and the bit value.
// Depends on pwcd_pkg.
module pwcd_check (
  input  logic [pwcd_pkg::WIDTH_W-1:0] width,
  input  logic                         level_low,
  input  logic [pwcd_pkg::WIDTH_W-1:0] high_width,
  input  logic [pwcd_pkg::WIDTH_W-1:0] low_width,
  input  logic [pwcd_pkg::WIDTH_W-1:0] sync_width,
  input  logic [pwcd_pkg::WIDTH_W-1:0] short_min_us,
  input  logic [pwcd_pkg::WIDTH_W-1:0] short_max_us,
  input  logic [pwcd_pkg::WIDTH_W-1:0] stop_min_us,
  output pwcd_pkg::check_t             chk
);

  logic [pwcd_pkg::WIDTH_W+1:0] half_max;
  logic [pwcd_pkg::WIDTH_W:0]   cycle;
  logic [pwcd_pkg::WIDTH_W+2:0] cycle_max;
  logic [pwcd_pkg::WIDTH_W-1:0] diff;

  always_comb begin
    half_max  = {sync_width, 2'b00};
    cycle_max = {sync_width, 3'b000};
    cycle     = {1'b0, high_width} + {1'b0, low_width};
    diff      = (high_width > low_width) ? (high_width - low_width)
                                         : (low_width - high_width);

    // low_width here is the stored one, a sync edge never updates it
    chk.sync_start = level_low && (width >= short_min_us) && (width <= short_max_us)
                     && (low_width >= stop_min_us);
    chk.half_ok    = !((width < (sync_width >> 1))
                       || ({2'b00, width} > half_max));
    chk.cycle_ok   = !((cycle < {1'b0, sync_width})
                       || ({2'b00, cycle} > cycle_max)
                       || ({1'b0, diff} < (cycle >> 3)));
    chk.bit_val    = low_width < high_width;
  end

endmodule

// ===== rtl/core/rf_pulse_width_code_decoder.sv =====
// Pulse-width remote code decoder: turns receiver edges into 12-bit frames.
// A frame result is in the output register in the cycle after its last edge is accepted.
// Throughput: one edge per cycle while in_ready is high; the edge state is updated on each accepted edge.
// Input is held off only while a result waits and out_ready is low.
// Reset (rst, synchronous): config and state registers back to defaults (frame_code and frame_time are not
// reset), decoder waits for sync. Depends on pwcd_pkg and pwcd_check.
module rf_pulse_width_code_decoder #(
  parameter int CODE_BITS = pwcd_pkg::CODE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pwcd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pwcd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pwcd_pkg::TIME_W-1:0]     edge_time,
  input  logic                            level_low,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pwcd_pkg::FRAME_W-1:0]    frame_code,
  output logic [pwcd_pkg::TIME_W-1:0]     frame_time
);

  localparam int CNT_W = $clog2(CODE_BITS + 1);

  logic [pwcd_pkg::WIDTH_W-1:0] short_min_us;
  logic [pwcd_pkg::WIDTH_W-1:0] short_max_us;
  logic [pwcd_pkg::WIDTH_W-1:0] stop_min_us;
  logic                         msb_first;

  logic                         in_data;
  logic [CNT_W-1:0]             bit_count;
  logic [CODE_BITS-1:0]         shift_code;
  logic [pwcd_pkg::TIME_W-1:0]  prev_edge_time;
  logic [pwcd_pkg::WIDTH_W-1:0] high_width;
  logic [pwcd_pkg::WIDTH_W-1:0] low_width;
  logic [pwcd_pkg::WIDTH_W-1:0] sync_width;

  logic                         in_fire;
  logic [pwcd_pkg::TIME_W-1:0]  elapsed;
  logic [pwcd_pkg::WIDTH_W-1:0] width;
  logic [pwcd_pkg::WIDTH_W-1:0] high_width_next;
  logic [pwcd_pkg::WIDTH_W-1:0] low_width_next;
  logic [CODE_BITS-1:0]         code_shifted;
  logic [CNT_W:0]               count_inc;
  logic                         bit_take;
  logic                         emit;
  logic [CODE_BITS+pwcd_pkg::FRAME_W-1:0] code_ext;
  pwcd_pkg::check_t             chk;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    elapsed         = edge_time - prev_edge_time;
    // saturate long gaps to the 16-bit maximum
    width           = (|elapsed[pwcd_pkg::TIME_W-1:pwcd_pkg::WIDTH_W])
                      ? {pwcd_pkg::WIDTH_W{1'b1}} : elapsed[pwcd_pkg::WIDTH_W-1:0];
    high_width_next = level_low ? width : high_width;
    low_width_next  = level_low ? low_width : width;
  end

  pwcd_check u_check (
    .width        (width),
    .level_low    (level_low),
    .high_width   (high_width_next),
    .low_width    (low_width_next),
    .sync_width   (sync_width),
    .short_min_us (short_min_us),
    .short_max_us (short_max_us),
    .stop_min_us  (stop_min_us),
    .chk          (chk)
  );

  always_comb begin
    if (msb_first) begin
      code_shifted = (shift_code << 1) | CODE_BITS'(chk.bit_val);
    end else begin
      code_shifted = (shift_code >> 1) | (CODE_BITS'(chk.bit_val) << (CODE_BITS - 1));
    end
    count_inc = {1'b0, bit_count} + (CNT_W + 1)'(1);
    bit_take  = in_data && chk.half_ok && level_low && chk.cycle_ok;
    emit      = bit_take && (count_inc >= (CNT_W + 1)'(CODE_BITS));
    code_ext  = {{pwcd_pkg::FRAME_W{1'b0}}, code_shifted};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_min_us <= pwcd_pkg::SHORT_MIN_RST;
      short_max_us <= pwcd_pkg::SHORT_MAX_RST;
      stop_min_us  <= pwcd_pkg::STOP_MIN_RST;
      msb_first    <= pwcd_pkg::MSB_FIRST_RST;
    end else if (cfg_we) begin
      unique case (pwcd_pkg::cfg_idx_t'(cfg_addr))
        pwcd_pkg::CFG_SHORT_MIN: short_min_us <= cfg_wdata;
        pwcd_pkg::CFG_SHORT_MAX: short_max_us <= cfg_wdata;
        pwcd_pkg::CFG_STOP_MIN:  stop_min_us  <= cfg_wdata;
        pwcd_pkg::CFG_MSB_FIRST: msb_first    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // edge state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_data        <= 1'b0;
      bit_count      <= '0;
      shift_code     <= '0;
      prev_edge_time <= '0;
      high_width     <= '0;
      low_width      <= '0;
      sync_width     <= '0;
    end else if (in_fire) begin
      prev_edge_time <= edge_time;
      high_width     <= high_width_next;
      low_width      <= low_width_next;
      if (!in_data) begin
        if (chk.sync_start) begin
          in_data    <= 1'b1;
          bit_count  <= '0;
          shift_code <= '0;
          sync_width <= width;
        end
      end else if (!chk.half_ok) begin
        in_data <= 1'b0;
      end else if (level_low) begin
        if (!chk.cycle_ok) begin
          in_data <= 1'b0;
        end else begin
          shift_code <= code_shifted;
          if (emit) begin
            in_data   <= 1'b0;
            bit_count <= '0;
          end else begin
            bit_count <= count_inc[CNT_W-1:0];
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      frame_code <= code_ext[pwcd_pkg::FRAME_W-1:0];
      frame_time <= prev_edge_time;
    end
  end

`ifndef SYNTHESIS
  a_emit_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit) |=> (!in_data && out_valid))
    else $error("frame still open after result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, bit_count} < (CNT_W + 1)'(CODE_BITS)))
    else $error("bit counter out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("result without accepted edge");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_data))
    else $error("not idle after reset");
`endif

endmodule
